// ----- rtl/qsort_pkg.sv -----
// Shared constants and helpers for the iterative quicksort engine.
// No dependencies; used by the top level and its port checker.
package qsort_pkg;

  localparam int MAX_KEYS_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int TOT_W        = 12;

  localparam logic [TOT_W-1:0] SAT_MAX = {TOT_W{1'b1}};

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TOT_W-1:0] tot_t;

  // Increment, holding at full scale
  function automatic tot_t sat_inc(input tot_t v);
    sat_inc = (v == SAT_MAX) ? v : v + tot_t'(1);
  endfunction

endpackage

// ----- rtl/iterative_quicksort_engine.sv -----
// Iterative quicksort engine: collects signed keys, sorts them in place
// (Lomuto partitions, explicit range stack) and streams them out ascending.
// Depends on qsort_pkg.

// Loading takes one cycle per key. The key with in_tlast set starts the sort,
// and in_tready stays low until the last sorted key has been handed to the
// output register. Work is bound by the single write port of the key memory:
// each partition pops a range and reads its pivot, then reads and compares
// each key in turn with one more step for each swap, then swaps the pivot
// into place and pushes the sub-ranges. Emit reads each key from memory, then
// loads it into the output register once that register is free. Keys beyond
// MAX_KEYS in one set are dropped. compare_total and move_total saturate at
// 4095 and repeat on every key of the run.
module iterative_quicksort_engine #(
  parameter int MAX_KEYS = qsort_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: key_in[31:0]
  input  logic [qsort_pkg::KEY_W-1:0]   in_tdata,
  input  logic                          in_tlast,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: key_out[31:0], compare_total[43:32], move_total[55:44]
  output logic [qsort_pkg::KEY_W+2*qsort_pkg::TOT_W-1:0] out_tdata,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready
);

  import qsort_pkg::*;

  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = IW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POP  = 4'd1;
  localparam logic [3:0] S_POPW = 4'd2;
  localparam logic [3:0] S_PIV  = 4'd3;
  localparam logic [3:0] S_JCHK = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SWP2 = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_FIN2 = 4'd8;
  localparam logic [3:0] S_PSH1 = 4'd9;
  localparam logic [3:0] S_PSH2 = 4'd10;
  localparam logic [3:0] S_EMRD = 4'd11;
  localparam logic [3:0] S_EMLD = 4'd12;

  localparam logic [CW-1:0] FULL = CW'(MAX_KEYS);

  // Memories
  key_t            key_mem   [MAX_KEYS];
  logic [2*IW-1:0] stack_mem [MAX_KEYS];

  // Memory ports
  logic          rda_en, rdb_en, kwr_en, sw_en, sr_en;
  logic [IW-1:0] rda_addr, rdb_addr, kwr_addr, sw_addr, sr_addr;
  key_t          kwr_data, rda_r, rdb_r;
  logic [2*IW-1:0] sw_data, stk_rd_r;

  // Control and datapath registers
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt, fill_r, fill_nxt, k_r, k_nxt;
  key_t          pivot_r, pivot_nxt, kf_r, kf_nxt;
  tot_t          cmp_r, cmp_nxt, mov_r, mov_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  key_t          out_key_r, out_key_nxt;
  tot_t          out_cmp_r, out_cmp_nxt, out_mov_r, out_mov_nxt;

  logic          in_xfer;
  logic [CW-1:0] cnt_inc;
  logic [IW:0]   lo_p1, fill_p1, k_p1;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cnt_inc   = (count_r < FULL) ? count_r + CW'(1) : count_r;
  assign lo_p1     = {1'b0, lo_r} + (IW+1)'(1);
  assign fill_p1   = {1'b0, fill_r} + (IW+1)'(1);
  assign k_p1      = {1'b0, k_r} + (IW+1)'(1);

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_mov_r, out_cmp_r, out_key_r};

  // Key memory: two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (kwr_en) key_mem[kwr_addr] <= kwr_data;
    if (rda_en) rda_r <= key_mem[rda_addr];
    if (rdb_en) rdb_r <= key_mem[rdb_addr];
  end

  // Range stack memory: {lo, hi} per entry
  always_ff @(posedge clk) begin
    if (sw_en) stack_mem[sw_addr] <= sw_data;
    if (sr_en) stk_rd_r <= stack_mem[sr_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    kf_nxt        = kf_r;
    cmp_nxt       = cmp_r;
    mov_nxt       = mov_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_key_nxt   = out_key_r;
    out_cmp_nxt   = out_cmp_r;
    out_mov_nxt   = out_mov_r;
    rda_en = 1'b0; rda_addr = j_r;
    rdb_en = 1'b0; rdb_addr = fill_r;
    kwr_en = 1'b0; kwr_addr = fill_r; kwr_data = rda_r;
    sw_en  = 1'b0; sw_addr  = top_r[IW-1:0]; sw_data = {lo_r, hi_r};
    sr_en  = 1'b0; sr_addr  = IW'(top_r - CW'(1));

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // Store the key unless the store is full
          if (count_r < FULL) begin
            kwr_en   = 1'b1;
            kwr_addr = count_r[IW-1:0];
            kwr_data = in_tdata;
          end
          count_nxt = cnt_inc;
          if (in_tlast) begin
            // Seed the stack with the whole range
            sw_en     = 1'b1;
            sw_addr   = '0;
            sw_data   = {IW'(0), IW'(cnt_inc - CW'(1))};
            top_nxt   = CW'(1);
            cmp_nxt   = '0;
            mov_nxt   = '0;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (top_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMRD;
        end else begin
          sr_en     = 1'b1;
          top_nxt   = top_r - CW'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        lo_nxt    = stk_rd_r[2*IW-1:IW];
        hi_nxt    = stk_rd_r[IW-1:0];
        rda_en    = 1'b1;
        rda_addr  = stk_rd_r[IW-1:0];
        state_nxt = S_PIV;
      end
      S_PIV: begin
        pivot_nxt = rda_r;
        j_nxt     = lo_r;
        fill_nxt  = lo_r;
        state_nxt = S_JCHK;
      end
      S_JCHK: begin
        rdb_en = 1'b1;
        if (j_r < hi_r) begin
          rda_en    = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CMP: begin
        cmp_nxt = sat_inc(cmp_r);
        if ($signed(rda_r) < $signed(pivot_r)) begin
          // First half of the swap: key[j] goes to the fill slot
          kwr_en    = 1'b1;
          kwr_addr  = fill_r;
          kwr_data  = rda_r;
          kf_nxt    = rdb_r;
          state_nxt = S_SWP2;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_JCHK;
        end
      end
      S_SWP2: begin
        kwr_en    = 1'b1;
        kwr_addr  = j_r;
        kwr_data  = kf_r;
        mov_nxt   = sat_inc(mov_r);
        fill_nxt  = fill_r + IW'(1);
        j_nxt     = j_r + IW'(1);
        state_nxt = S_JCHK;
      end
      S_FIN: begin
        // Pivot into its final slot
        kwr_en    = 1'b1;
        kwr_addr  = fill_r;
        kwr_data  = pivot_r;
        kf_nxt    = rdb_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        kwr_en    = 1'b1;
        kwr_addr  = hi_r;
        kwr_data  = kf_r;
        mov_nxt   = sat_inc(mov_r);
        state_nxt = S_PSH1;
      end
      S_PSH1: begin
        // Left part, when it holds more than one key; dropped when the stack is full
        if (({1'b0, fill_r} > lo_p1) && (top_r < FULL)) begin
          sw_en   = 1'b1;
          sw_data = {lo_r, fill_r - IW'(1)};
          top_nxt = top_r + CW'(1);
        end
        state_nxt = S_PSH2;
      end
      S_PSH2: begin
        if ((fill_p1 < {1'b0, hi_r}) && (top_r < FULL)) begin
          sw_en   = 1'b1;
          sw_data = {fill_p1[IW-1:0], hi_r};
          top_nxt = top_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_EMRD: begin
        rda_en    = 1'b1;
        rda_addr  = k_r;
        state_nxt = S_EMLD;
      end
      S_EMLD: begin
        // Load the output register with the key and this run's totals
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = rda_r;
          out_cmp_nxt   = cmp_r;
          out_mov_nxt   = mov_r;
          out_last_nxt  = (k_p1 == count_r);
          if (k_p1 == count_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_p1[IW-1:0];
            state_nxt = S_EMRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      cmp_r       <= '0;
      mov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      cmp_r       <= cmp_nxt;
      mov_r       <= mov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    fill_r     <= fill_nxt;
    k_r        <= k_nxt;
    pivot_r    <= pivot_nxt;
    kf_r       <= kf_nxt;
    out_last_r <= out_last_nxt;
    out_key_r  <= out_key_nxt;
    out_cmp_r  <= out_cmp_nxt;
    out_mov_r  <= out_mov_nxt;
  end

endmodule

// ----- rtl/qsort_checker.sv -----
// Port-level checks for the iterative quicksort engine, bound to the top level.
// Depends on qsort_pkg and iterative_quicksort_engine.
module qsort_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tlast,
  input logic [qsort_pkg::KEY_W+2*qsort_pkg::TOT_W-1:0] out_tdata,
  input logic                                out_tlast,
  input logic                                out_tvalid,
  input logic                                out_tready
);

  import qsort_pkg::*;

  // A closing transfer starts the sort; input stalls right after
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after closing transfer");

  // Every sort makes at least the pivot swap
  a_moves_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[KEY_W+2*TOT_W-1:KEY_W+TOT_W] != '0))
    else $error("result with zero move total");

  // A stalled result holds valid
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result holds its payload
  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind iterative_quicksort_engine qsort_checker u_qsort_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ----- tb/iterative_quicksort_engine_checker.sv -----
`timescale 1ns / 1ps
// Checker for the iterative quicksort engine: watches both stream ports,
// predicts the sorted run and its totals, and compares each output transfer.
// Depends on qsort_pkg for the key and total types.
module iterative_quicksort_engine_checker #(
  parameter int MAX_KEYS = qsort_pkg::MAX_KEYS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [qsort_pkg::KEY_W-1:0] in_tdata,
  input  logic                     in_tlast,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [qsort_pkg::KEY_W+2*qsort_pkg::TOT_W-1:0] out_tdata,
  input  logic                     out_tlast,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  output int                       fail_count,
  output int                       pending
);

  import qsort_pkg::*;

  typedef struct packed {
    key_t key;
    logic last;
    tot_t compares;
    tot_t moves;
  } sorted_key_t;

  sorted_key_t sorted_q[$];

  // Shadow of the engine's key memory, range stack and tallies
  key_t set_keys[MAX_KEYS];
  int   set_count;
  int   range_lo[MAX_KEYS];
  int   range_hi[MAX_KEYS];
  int   range_depth;
  tot_t compare_tally;
  tot_t move_tally;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic tot_t tally_up(input tot_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void swap_keys(input int a, input int b);
    key_t t;
    t           = set_keys[a];
    set_keys[a] = set_keys[b];
    set_keys[b] = t;
    move_tally  = tally_up(move_tally);
  endfunction

  function automatic void push_range(input int lo, input int hi);
    if (range_depth < MAX_KEYS) begin
      range_lo[range_depth] = lo;
      range_hi[range_depth] = hi;
      range_depth++;
    end
  endfunction

  // Lomuto partition around the last key of the range; returns pivot slot
  function automatic int partition_range(input int lo, input int hi);
    key_t pivot;
    int   fill;
    pivot = set_keys[hi];
    fill  = lo;
    for (int j = lo; j < hi; j++) begin
      compare_tally = tally_up(compare_tally);
      if ($signed(set_keys[j]) < $signed(pivot)) begin
        swap_keys(fill, j);
        fill++;
      end
    end
    swap_keys(fill, hi);
    return fill;
  endfunction

  // Sort the held set and queue one expected transfer per key
  function automatic void sort_and_queue();
    int lo;
    int hi;
    int p;
    sorted_key_t rec;
    compare_tally = '0;
    move_tally    = '0;
    range_depth   = 0;
    push_range(0, set_count - 1);
    while (range_depth > 0) begin
      range_depth--;
      lo = range_lo[range_depth];
      hi = range_hi[range_depth];
      p  = partition_range(lo, hi);
      if (p > lo + 1) push_range(lo, p - 1);
      if (p + 1 < hi) push_range(p + 1, hi);
    end
    for (int k = 0; k < set_count; k++) begin
      rec.key      = set_keys[k];
      rec.last     = (k == set_count - 1);
      rec.compares = compare_tally;
      rec.moves    = move_tally;
      sorted_q.push_back(rec);
    end
    set_count = 0;
  endfunction

  always @(posedge clk) begin
    sorted_key_t seen;
    sorted_key_t want;
    if (!rst_n) begin
      set_count   = 0;
      range_depth = 0;
      sorted_q.delete();
    end else begin
      // Check the output transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        seen.key      = out_tdata[KEY_W-1:0];
        seen.last     = out_tlast;
        seen.compares = out_tdata[KEY_W+TOT_W-1:KEY_W];
        seen.moves    = out_tdata[KEY_W+2*TOT_W-1:KEY_W+TOT_W];
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected output key %0d last %0b cmp %0d mov %0d",
                   $time, $signed(seen.key), seen.last, seen.compares, seen.moves);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (seen !== want) begin
            $display({"%0t: expected key %0d last %0b cmp %0d mov %0d, ",
                      "got key %0d last %0b cmp %0d mov %0d"},
                     $time, $signed(want.key), want.last, want.compares, want.moves,
                     $signed(seen.key), seen.last, seen.compares, seen.moves);
            fail_count++;
          end
        end
      end
      // Store the input key; drop it when the set is full
      if (in_tvalid && in_tready) begin
        if (set_count < MAX_KEYS) begin
          set_keys[set_count] = in_tdata;
          set_count++;
        end
        if (in_tlast) sort_and_queue();
      end
    end
    pending <= sorted_q.size();
  end

endmodule

// ----- tb/iterative_quicksort_engine_tb.sv -----
`timescale 1ns / 1ps
// Top of the quicksort engine testbench: clock, reset, key stimulus and
// output back-pressure. Depends on qsort_pkg, the engine and its checker.
module iterative_quicksort_engine_tb;
  import qsort_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int PHASE_ITEMS = 150;

  typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_ASCENDING, FILL_DESCENDING} fill_mode_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic [KEY_W-1:0]         in_tdata   = '0;
  logic                     in_tlast   = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [KEY_W+2*TOT_W-1:0] out_tdata;
  logic                     out_tlast;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;

  int fail_count;
  int pending;
  int tx_idle    = 34;
  int rx_idle    = 63;
  int items_sent = 0;
  int phase      = 0;

  iterative_quicksort_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  iterative_quicksort_engine_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the output side at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // Offer one key, idling first at random, and hold it until the transfer
  task automatic send_key(input key_t key, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= key;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Hold the input until every queued sorted key has come out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_set(input int n, input fill_mode_t mode);
    key_t base;
    key_t step;
    key_t key;
    base = $urandom();
    step = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      case (mode)
        FILL_RANDOM:     key = $urandom();
        FILL_NARROW:     key = key_t'(int'($urandom_range(0, 7)) - 4);
        FILL_ASCENDING:  key = base + key_t'(i) * step;
        FILL_DESCENDING: key = base - key_t'(i) * step;
        default:         key = $urandom();
      endcase
      send_key(key, i == n - 1);
    end
  endtask

  initial begin
    int         pick;
    int         set_size;
    fill_mode_t mode;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single keys at both extremes
    send_key(32'h8000_0000, 1'b1);
    send_key(32'h7fff_ffff, 1'b1);
    // Pair, then a mix of extremes
    send_key(32'h0000_0000, 1'b0);
    send_key(32'hffff_ffff, 1'b1);
    send_key(32'h7fff_ffff, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'hffff_ffff, 1'b0);
    send_key(32'h0000_0001, 1'b1);
    // Strictly descending set
    send_key(32'd100, 1'b0);
    send_key(32'd50, 1'b0);
    send_key(32'd0, 1'b0);
    send_key(-32'sd50, 1'b0);
    send_key(-32'sd100, 1'b0);
    send_key(-32'sd150, 1'b1);
    // All keys equal
    repeat (3) send_key(32'd5, 1'b0);
    send_key(32'd5, 1'b1);

    // Random sets; sizes past the store depth exercise the full-store drop
    while (items_sent < ITEM_TARGET) begin
      if (phase < 2 && items_sent >= PHASE_ITEMS * (phase + 1)) begin
        drain();
        phase++;
        tx_idle = (phase == 1) ? 63 : 0;
        rx_idle = (phase == 1) ? 34 : 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)      set_size = $urandom_range(1, 6);
      else if (pick < 85) set_size = $urandom_range(7, 20);
      else if (pick < 95) set_size = $urandom_range(21, MAX_KEYS_DEF);
      else                set_size = $urandom_range(MAX_KEYS_DEF + 1, MAX_KEYS_DEF + 4);
      pick = $urandom_range(0, 99);
      if (pick < 50)      mode = FILL_RANDOM;
      else if (pick < 70) mode = FILL_NARROW;
      else if (pick < 85) mode = FILL_ASCENDING;
      else                mode = FILL_DESCENDING;
      send_set(set_size, mode);
    end

    drain();
    repeat (64) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("iterative_quicksort_engine_tb: PASS");
    end else begin
      $display("iterative_quicksort_engine_tb: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("iterative_quicksort_engine_tb: FAIL");
    $finish;
  end

endmodule
